// ===== hdl/tpd_pkg.sv =====
// Shared definitions for the three-point derivative estimator.
// Default widths for the top-level parameters; no dependencies.
`timescale 1ns / 1ps

package tpd_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

endpackage

// ===== hdl/three_point_derivative_estimator.sv =====
// Three-point derivative estimator, top level.
// Instantiates tpd_div (chains of tpd_cell); depends on tpd_pkg.
`timescale 1ns / 1ps

// The block accepts one transfer per cycle while not stalled and returns one
// result transfer per input. It is built from two chained restoring dividers
// of one bit per cell: the three slopes in parallel, then the second
// derivative. The pipeline moves as a whole; it stalls only while a result
// sits in the output register and m_tready is low. center_from_mean is
// written through cfg_we/cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this.

module three_point_derivative_estimator
    import tpd_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_data,
    input  logic s_tvalid,
    output logic s_tready,
    // x_left, x_center, x_right, y_left, y_center, y_right, zero pad
    input  logic [((6*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // slope_right_left, slope_right_center, slope_center_left,
    // second_derivative, zero_divisor_mask, saturated_mask, zero pad
    output logic [((4*DATA_WIDTH+8+7)/8)*8-1:0] m_tdata
);

    localparam int DW  = DATA_WIDTH;
    localparam int IW  = ((6*DW+7)/8)*8;
    localparam int OW  = ((4*DW+8+7)/8)*8;
    localparam int TW2 = 3*DW + 6;

    logic en;
    logic center_from_mean_reg;

    logic          a_valid_reg;
    logic [DW-1:0] xl_reg, xc_reg, xr_reg, yl_reg, yc_reg, yr_reg;
    logic [DW:0]   sum_x, sum_y;
    logic [DW-1:0] xc_sel, yc_sel;

    logic               b_valid_reg;
    logic signed [DW:0] n_rl_reg, d_rl_reg, n_rc_reg, d_rc_reg, n_cl_reg, d_cl_reg;

    logic          v1;
    logic [DW-1:0] s_rl, s_rc, s_cl;
    logic [2:0]    z1, sat1;
    logic [DW:0]   d_rl_dly;

    logic signed [DW:0] slope_diff;
    logic [TW2-1:0]     tag2, tag2_o;
    logic [DW-1:0]      d2;
    logic               z2, sat2;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_from_mean_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            center_from_mean_reg <= cfg_data;
        end
    end

    // stage A: hold the accepted points
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xl_reg <= s_tdata[0*DW +: DW];
            xc_reg <= s_tdata[1*DW +: DW];
            xr_reg <= s_tdata[2*DW +: DW];
            yl_reg <= s_tdata[3*DW +: DW];
            yc_reg <= s_tdata[4*DW +: DW];
            yr_reg <= s_tdata[5*DW +: DW];
        end
    end

    // mean center: floor of the half sum
    always_comb
    begin
        sum_x  = {xl_reg[DW-1], xl_reg} + {xr_reg[DW-1], xr_reg};
        sum_y  = {yl_reg[DW-1], yl_reg} + {yr_reg[DW-1], yr_reg};
        xc_sel = center_from_mean_reg ? sum_x[DW:1] : xc_reg;
        yc_sel = center_from_mean_reg ? sum_y[DW:1] : yc_reg;
    end

    // stage B: full-precision differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_rl_reg <= $signed({yr_reg[DW-1], yr_reg}) - $signed({yl_reg[DW-1], yl_reg});
            d_rl_reg <= $signed({xr_reg[DW-1], xr_reg}) - $signed({xl_reg[DW-1], xl_reg});
            n_rc_reg <= $signed({yr_reg[DW-1], yr_reg}) - $signed({yc_sel[DW-1], yc_sel});
            d_rc_reg <= $signed({xr_reg[DW-1], xr_reg}) - $signed({xc_sel[DW-1], xc_sel});
            n_cl_reg <= $signed({yc_sel[DW-1], yc_sel}) - $signed({yl_reg[DW-1], yl_reg});
            d_cl_reg <= $signed({xc_sel[DW-1], xc_sel}) - $signed({xl_reg[DW-1], xl_reg});
        end
    end

    tpd_div #(.DW(DW), .FB(FRAC_BITS), .TW(DW+1)) u_div_rl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (b_valid_reg),
        .num_i   ({n_rl_reg[DW], n_rl_reg}),
        .den_i   (d_rl_reg),
        .tag_i   (d_rl_reg),
        .valid_o (v1),
        .quo_o   (s_rl),
        .zero_o  (z1[0]),
        .sat_o   (sat1[0]),
        .tag_o   (d_rl_dly)
    );

    tpd_div #(.DW(DW), .FB(FRAC_BITS), .TW(1)) u_div_rc
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (b_valid_reg),
        .num_i   ({n_rc_reg[DW], n_rc_reg}),
        .den_i   (d_rc_reg),
        .tag_i   (1'b0),
        .valid_o (),
        .quo_o   (s_rc),
        .zero_o  (z1[1]),
        .sat_o   (sat1[1]),
        .tag_o   ()
    );

    tpd_div #(.DW(DW), .FB(FRAC_BITS), .TW(1)) u_div_cl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (b_valid_reg),
        .num_i   ({n_cl_reg[DW], n_cl_reg}),
        .den_i   (d_cl_reg),
        .tag_i   (1'b0),
        .valid_o (),
        .quo_o   (s_cl),
        .zero_o  (z1[2]),
        .sat_o   (sat1[2]),
        .tag_o   ()
    );

    // second derivative works on the clipped slopes
    always_comb
    begin
        slope_diff = $signed({s_rc[DW-1], s_rc}) - $signed({s_cl[DW-1], s_cl});
        tag2       = {sat1, z1, s_cl, s_rc, s_rl};
    end

    tpd_div #(.DW(DW), .FB(FRAC_BITS), .TW(TW2)) u_div_d2
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (v1),
        .num_i   ({slope_diff, 1'b0}),
        .den_i   (d_rl_dly),
        .tag_i   (tag2),
        .valid_o (m_tvalid),
        .quo_o   (d2),
        .zero_o  (z2),
        .sat_o   (sat2),
        .tag_o   (tag2_o)
    );

    assign m_tdata = {{(OW-4*DW-8){1'b0}},
                      sat2, tag2_o[3*DW+5:3*DW+3],
                      z2, tag2_o[3*DW+2:3*DW],
                      d2, tag2_o[3*DW-1:0]};

endmodule

// ===== hdl/tpd_cell.sv =====
// One restoring-division step: shift in one dividend bit, compare, subtract.
// Used in a chain by tpd_div; depends on tpd_pkg for its parameter defaults.
`timescale 1ns / 1ps

module tpd_cell
    import tpd_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF,
    parameter int NW = DATA_WIDTH_DEF + FRAC_BITS_DEF + 2,
    parameter int TW = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_i,
    input  logic [DW-1:0] rem_i,
    input  logic [NW-1:0] num_i,
    input  logic [DW:0]   den_i,
    input  logic [DW:0]   q_i,
    input  logic          ovf_i,
    input  logic [TW-1:0] tag_i,
    output logic          valid_o,
    output logic [DW-1:0] rem_o,
    output logic [NW-1:0] num_o,
    output logic [DW:0]   den_o,
    output logic [DW:0]   q_o,
    output logic          ovf_o,
    output logic [TW-1:0] tag_o
);

    logic [DW:0]   shifted;
    logic          ge;
    logic [DW:0]   diff;

    always_comb
    begin
        shifted = {rem_i, num_i[NW-1]};
        ge      = (shifted >= den_i);
        diff    = shifted - den_i;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_o <= 1'b0;
        end
        else if (en)
        begin
            valid_o <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // remainder stays below the divisor, so DW bits hold it
            rem_o <= ge ? diff[DW-1:0] : shifted[DW-1:0];
            num_o <= {num_i[NW-2:0], 1'b0};
            den_o <= den_i;
            q_o   <= {q_i[DW-1:0], ge};
            ovf_o <= ovf_i | q_i[DW];
            tag_o <= tag_i;
        end
    end

endmodule

// ===== hdl/tpd_div.sv =====
// Pipelined signed fixed-point divider: (num << FB) / den, truncated, clipped.
// Built from a chain of tpd_cell steps; depends on tpd_pkg.
`timescale 1ns / 1ps

module tpd_div
    import tpd_pkg::*;
#(
    parameter int DW = DATA_WIDTH_DEF,
    parameter int FB = FRAC_BITS_DEF,
    parameter int TW = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 valid_i,
    input  logic signed [DW+1:0] num_i,
    input  logic signed [DW:0]   den_i,
    input  logic [TW-1:0]        tag_i,
    output logic                 valid_o,
    output logic [DW-1:0]        quo_o,
    output logic                 zero_o,
    output logic                 sat_o,
    output logic [TW-1:0]        tag_o
);

    localparam int NW = DW + 2 + FB;
    localparam int EW = TW + 4;

    logic [DW+1:0] nmag;
    logic [DW:0]   dmag;

    logic [NW:0]          valid_c;
    logic [DW-1:0]        rem_c [0:NW];
    logic [NW-1:0]        num_c [0:NW];
    logic [DW:0]          den_c [0:NW];
    logic [DW:0]          q_c   [0:NW];
    logic [NW:0]          ovf_c;
    logic [EW-1:0]        ext_c [0:NW];

    logic          zero_l, neg_l, pos_l, nz_l;
    logic [DW:0]   q_l;
    logic          sat_l;
    logic [DW-1:0] res_l;

    always_comb
    begin
        nmag = num_i[DW+1] ? (~num_i + 1'b1) : num_i;
        dmag = den_i[DW] ? (~den_i + 1'b1) : den_i;
    end

    // entry stage: magnitudes, sign flags and zero flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_c[0] <= valid_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_c[0]   <= '0;
            num_c[0]   <= {nmag, {FB{1'b0}}};
            den_c[0]   <= dmag;
            q_c[0]     <= '0;
            ovf_c[0]   <= 1'b0;
            ext_c[0]   <= {tag_i, (den_i == '0), (num_i[DW+1] != den_i[DW]),
                           (!num_i[DW+1] && (num_i != '0)), (num_i != '0)};
        end
    end

    genvar i;
    generate
        for (i = 0; i < NW; i++)
        begin : g_cell
            tpd_cell #(.DW(DW), .NW(NW), .TW(EW)) u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en),
                .valid_i (valid_c[i]),
                .rem_i   (rem_c[i]),
                .num_i   (num_c[i]),
                .den_i   (den_c[i]),
                .q_i     (q_c[i]),
                .ovf_i   (ovf_c[i]),
                .tag_i   (ext_c[i]),
                .valid_o (valid_c[i+1]),
                .rem_o   (rem_c[i+1]),
                .num_o   (num_c[i+1]),
                .den_o   (den_c[i+1]),
                .q_o     (q_c[i+1]),
                .ovf_o   (ovf_c[i+1]),
                .tag_o   (ext_c[i+1])
            );
        end
    endgenerate

    // sign, zero-divisor and clip handling on the finished quotient
    always_comb
    begin
        zero_l = ext_c[NW][3];
        neg_l  = ext_c[NW][2];
        pos_l  = ext_c[NW][1];
        nz_l   = ext_c[NW][0];
        q_l    = q_c[NW];
        sat_l  = 1'b0;
        res_l  = '0;
        if (zero_l)
        begin
            if (pos_l)
                res_l = {1'b0, {(DW-1){1'b1}}};
            else if (nz_l)
                res_l = {1'b1, {(DW-1){1'b0}}};
        end
        else if (!neg_l)
        begin
            sat_l = ovf_c[NW] | q_l[DW] | q_l[DW-1];
            res_l = sat_l ? {1'b0, {(DW-1){1'b1}}} : q_l[DW-1:0];
        end
        else
        begin
            sat_l = ovf_c[NW] | q_l[DW] | (q_l[DW-1] & (|q_l[DW-2:0]));
            res_l = sat_l ? {1'b1, {(DW-1){1'b0}}} : (~q_l[DW-1:0] + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_o <= 1'b0;
        end
        else if (en)
        begin
            valid_o <= valid_c[NW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_o  <= res_l;
            zero_o <= zero_l;
            sat_o  <= sat_l;
            tag_o  <= ext_c[NW][EW-1:4];
        end
    end

endmodule
